/* rtl/aae_pkg.sv */
`timescale 1ns / 1ps

package aae_pkg;

  localparam int unsigned CNT_W  = 5;
  localparam int unsigned TAL_W  = 6;
  localparam int unsigned AXES_W = 32;
  localparam int unsigned FIDX_W = 8;
  localparam int unsigned AXES_POS = AXES_W / 2;

  localparam logic [1:0] LAB_X = 2'd0;
  localparam logic [1:0] LAB_Y = 2'd1;
  localparam logic [1:0] LAB_Z = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  localparam logic REG_TOTAL_DEGREE = 1'b0;

  typedef struct packed {
    logic [AXES_W-1:0] axes;
    logic              done;
    logic              bad;
    logic [TAL_W-1:0]  tal_x;
    logic [TAL_W-1:0]  tal_y;
    logic [TAL_W-1:0]  tal_z;
    logic [CNT_W-1:0]  cnt_x;
    logic [CNT_W-1:0]  cnt_y;
    logic [CNT_W-1:0]  cnt_z;
  } out_req_t;

endpackage

/* rtl/aae_out_stage.sv */
`timescale 1ns / 1ps

module aae_out_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  aae_pkg::out_req_t              req,
  output logic                           slot_free,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [aae_pkg::AXES_W-1:0]     out_axes,
  output logic                           out_done_res,
  output logic                           out_bad_args,
  output logic                           out_arrangement_valid,
  output logic [aae_pkg::FIDX_W-1:0]     out_function_index
);

  logic                       valid_r, valid_nxt;
  logic [aae_pkg::AXES_W-1:0] axes_r;
  logic                       done_r, bad_r, ok_r;
  logic [aae_pkg::FIDX_W-1:0] fidx_r;

  logic                       ok_w;
  logic [5:0]                 cc_w;
  logic [11:0]                tri_w;
  logic [11:0]                fidx_w;

  assign slot_free = !valid_r || !out_stall;

  assign ok_w = (req.tal_x == aae_pkg::TAL_W'(req.cnt_x)) &&
                (req.tal_y == aae_pkg::TAL_W'(req.cnt_y)) &&
                (req.tal_z == aae_pkg::TAL_W'(req.cnt_z));

  // canonical index: c*(c+1)/2 + c - ny with c = ny + nz
  assign cc_w   = 6'(req.cnt_y) + 6'(req.cnt_z);
  assign tri_w  = (12'(cc_w) + 12'd1) * 12'(cc_w);
  assign fidx_w = (cc_w == 6'd0) ? 12'd0 :
                  (tri_w >> 1) + 12'(cc_w) - 12'(req.cnt_y);

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      axes_r <= req.axes;
      done_r <= req.done;
      bad_r  <= req.bad;
      ok_r   <= ok_w;
      fidx_r <= fidx_w[aae_pkg::FIDX_W-1:0];
    end
  end

  assign out_valid             = valid_r;
  assign out_axes              = axes_r;
  assign out_done_res          = done_r;
  assign out_bad_args          = bad_r;
  assign out_arrangement_valid = ok_r;
  assign out_function_index    = fidx_r;

endmodule

/* rtl/axis_arrangement_enumerator.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  cmd, count_x, count_y, count_z
// out_      output     out_valid/out_stall  axes, done_res, bad_args,
//                                           arrangement_valid, function_index
// cfg       APB slave  psel/penable/pready  total_degree at byte address 0
//
// One item at a time through a single position walker (compare, increment,
// write back one slot per cycle) followed by a one-label-per-cycle tally pass.
// An advance after the end or a rejected start goes straight to the tally pass.
// Synchronous active-low reset clears the sequencer and flags; position and
// label stores are not cleared. A stalled result waits in the output register
// while the next item is already taken and worked on.

module axis_arrangement_enumerator #(
  parameter int unsigned MAX_DEGREE = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_cmd,
  input  logic [aae_pkg::CNT_W-1:0]       in_count_x,
  input  logic [aae_pkg::CNT_W-1:0]       in_count_y,
  input  logic [aae_pkg::CNT_W-1:0]       in_count_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [aae_pkg::AXES_W-1:0]      out_axes,
  output logic                            out_done_res,
  output logic                            out_bad_args,
  output logic                            out_arrangement_valid,
  output logic [aae_pkg::FIDX_W-1:0]      out_function_index,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int unsigned CW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned LW = CW + 2;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FILL   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_SPREAD = 4'd3;
  localparam logic [3:0] S_ZRST   = 4'd4;
  localparam logic [3:0] S_BUILD  = 4'd5;
  localparam logic [3:0] S_TALLY  = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;

  logic [3:0]                 state_r, state_nxt;
  logic [aae_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic [aae_pkg::CNT_W-1:0]  cnt_x_r, cnt_x_nxt;
  logic [aae_pkg::CNT_W-1:0]  cnt_y_r, cnt_y_nxt;
  logic [aae_pkg::CNT_W-1:0]  cnt_z_r, cnt_z_nxt;
  logic                       fin_r, fin_nxt;
  logic                       bad_r, bad_nxt;
  logic [CW-1:0]              nz_r, nz_nxt;
  logic [CW-1:0]              ny_r, ny_nxt;
  logic                       sel_r, sel_nxt;
  logic [CW-1:0]              i_r, i_nxt;
  logic signed [LW-1:0]       lim_r, lim_nxt;
  logic [IW-1:0]              v_r, v_nxt;
  logic [CW-1:0]              cz_r, cz_nxt;
  logic [CW-1:0]              cy_r, cy_nxt;
  logic signed [LW-1:0]       free_r, free_nxt;
  logic [CW-1:0]              tx_r, tx_nxt;
  logic [CW-1:0]              ty_r, ty_nxt;
  logic [CW-1:0]              tz_r, tz_nxt;

  logic [IW-1:0]              z_pos_r [MAX_DEGREE];
  logic [IW-1:0]              y_pos_r [MAX_DEGREE];
  logic [1:0]                 lab_r   [MAX_DEGREE];

  logic                       z_we, y_we, lab_we;
  logic [IW-1:0]              z_wa, y_wa, lab_wa;
  logic [IW-1:0]              z_wd, y_wd;
  logic [1:0]                 lab_wd;

  logic                       go_tally, go_build, go_zrst;
  logic                       cfg_wr;
  logic                       in_acc;
  logic [5:0]                 tot6, d6, nz6, ny6, rem6;
  logic [6:0]                 sum7;
  logic [5:0]                 k6, cz6, cy6;
  logic [CW-1:0]              d_w;
  logic signed [LW-1:0]       span_y_w;
  logic                       start_bad_w;
  logic [IW-1:0]              pos_rd;
  logic signed [LW-1:0]       pos_s;
  logic [CW-1:0]              n_w;
  logic                       z_hit, y_hit;
  logic [aae_pkg::AXES_W-1:0] axes_w;
  logic                       slot_free;
  logic                       out_load;
  aae_pkg::out_req_t          req_w;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == aae_pkg::REG_TOTAL_DEGREE);
  assign prdata = (paddr[2] == aae_pkg::REG_TOTAL_DEGREE) ? 32'(total_r) : 32'd0;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);

  // effective degree, clipped to the store depth
  assign tot6 = 6'(total_r);
  assign d6   = (tot6 > 6'(MAX_DEGREE)) ? 6'(MAX_DEGREE) : tot6;
  assign d_w  = d6[CW-1:0];
  assign sum7 = 7'(in_count_x) + 7'(in_count_y) + 7'(in_count_z);
  assign start_bad_w = (tot6 > 6'(MAX_DEGREE)) || (sum7 != 7'(tot6));

  assign nz6  = (6'(cnt_z_r) > d6) ? d6 : 6'(cnt_z_r);
  assign rem6 = d6 - nz6;
  assign ny6  = (6'(cnt_y_r) > rem6) ? rem6 : 6'(cnt_y_r);

  assign span_y_w = $signed(LW'(d_w)) - $signed(LW'(nz_r));

  assign k6  = 6'(i_r);
  assign cz6 = 6'(cnt_z_r);
  assign cy6 = 6'(cnt_y_r);

  // shared walker read port
  assign pos_rd = sel_r ? y_pos_r[i_r[IW-1:0]] : z_pos_r[i_r[IW-1:0]];
  assign pos_s  = $signed(LW'(pos_rd));
  assign n_w    = sel_r ? ny_r : nz_r;

  assign z_hit = (cz_r < nz_r) && (z_pos_r[cz_r[IW-1:0]] == i_r[IW-1:0]);
  assign y_hit = (cy_r < ny_r) && ($signed(LW'(y_pos_r[cy_r[IW-1:0]])) == free_r);

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    cnt_x_nxt = cnt_x_r;
    cnt_y_nxt = cnt_y_r;
    cnt_z_nxt = cnt_z_r;
    fin_nxt   = fin_r;
    bad_nxt   = bad_r;
    nz_nxt    = nz_r;
    ny_nxt    = ny_r;
    sel_nxt   = sel_r;
    i_nxt     = i_r;
    lim_nxt   = lim_r;
    v_nxt     = v_r;
    cz_nxt    = cz_r;
    cy_nxt    = cy_r;
    free_nxt  = free_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    tz_nxt    = tz_r;
    z_we      = 1'b0;
    z_wa      = '0;
    z_wd      = '0;
    y_we      = 1'b0;
    y_wa      = '0;
    y_wd      = '0;
    lab_we    = 1'b0;
    lab_wa    = '0;
    lab_wd    = aae_pkg::LAB_X;
    go_tally  = 1'b0;
    go_build  = 1'b0;
    go_zrst   = 1'b0;

    if (cfg_wr) begin
      total_nxt = pwdata[aae_pkg::CNT_W-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == aae_pkg::CMD_START) begin
            if (start_bad_w) begin
              fin_nxt  = 1'b1;
              bad_nxt  = 1'b1;
              go_tally = 1'b1;
            end else begin
              bad_nxt   = 1'b0;
              cnt_x_nxt = in_count_x;
              cnt_y_nxt = in_count_y;
              cnt_z_nxt = in_count_z;
              if (tot6 == 6'd0) begin
                fin_nxt  = 1'b1;
                go_tally = 1'b1;
              end else begin
                fin_nxt   = 1'b0;
                i_nxt     = '0;
                state_nxt = S_FILL;
              end
            end
          end else begin
            bad_nxt = 1'b0;
            if (fin_r) begin
              go_tally = 1'b1;
            end else begin
              nz_nxt    = nz6[CW-1:0];
              ny_nxt    = ny6[CW-1:0];
              sel_nxt   = 1'b0;
              i_nxt     = '0;
              lim_nxt   = $signed(LW'(d_w)) - $signed(LW'(1));
              state_nxt = S_SCAN;
            end
          end
        end
      end

      // first arrangement: all z, then all y, then all x
      S_FILL: begin
        if (i_r == d_w) begin
          go_tally = 1'b1;
        end else begin
          lab_we = 1'b1;
          lab_wa = i_r[IW-1:0];
          if (k6 < cz6) begin
            lab_wd = aae_pkg::LAB_Z;
            z_we   = 1'b1;
            z_wa   = i_r[IW-1:0];
            z_wd   = IW'(cz6 - 6'd1 - k6);
          end else if (k6 < cz6 + cy6) begin
            lab_wd = aae_pkg::LAB_Y;
            y_we   = 1'b1;
            y_wa   = IW'(k6 - cz6);
            y_wd   = IW'(cz6 + cy6 - 6'd1 - k6);
          end else begin
            lab_wd = aae_pkg::LAB_X;
          end
          i_nxt = i_r + CW'(1);
        end
      end

      // find the lowest entry that can move up below its limit
      S_SCAN: begin
        if (i_r == n_w) begin
          if (!sel_r) begin
            sel_nxt = 1'b1;
            i_nxt   = '0;
            lim_nxt = span_y_w - $signed(LW'(1));
          end else begin
            fin_nxt  = 1'b1;
            go_tally = 1'b1;
          end
        end else if (pos_s < lim_r) begin
          z_we  = !sel_r;
          y_we  = sel_r;
          z_wa  = i_r[IW-1:0];
          y_wa  = i_r[IW-1:0];
          z_wd  = pos_rd + IW'(1);
          y_wd  = pos_rd + IW'(1);
          v_nxt = pos_rd + IW'(1);
          if (i_r == '0) begin
            go_build = !sel_r;
            go_zrst  = sel_r;
          end else begin
            i_nxt     = i_r - CW'(1);
            state_nxt = S_SPREAD;
          end
        end else begin
          lim_nxt = pos_s - $signed(LW'(1));
          i_nxt   = i_r + CW'(1);
        end
      end

      // pack the entries below the moved one right above it
      S_SPREAD: begin
        z_we  = !sel_r;
        y_we  = sel_r;
        z_wa  = i_r[IW-1:0];
        y_wa  = i_r[IW-1:0];
        z_wd  = v_r + IW'(1);
        y_wd  = v_r + IW'(1);
        v_nxt = v_r + IW'(1);
        if (i_r == '0) begin
          go_build = !sel_r;
          go_zrst  = sel_r;
        end else begin
          i_nxt = i_r - CW'(1);
        end
      end

      S_ZRST: begin
        if (i_r == nz_r) begin
          go_build = 1'b1;
        end else begin
          z_we  = 1'b1;
          z_wa  = i_r[IW-1:0];
          z_wd  = IW'(nz_r - CW'(1) - i_r);
          i_nxt = i_r + CW'(1);
        end
      end

      // rebuild labels from the top position down
      S_BUILD: begin
        lab_we = 1'b1;
        lab_wa = i_r[IW-1:0];
        if (z_hit) begin
          lab_wd = aae_pkg::LAB_Z;
          cz_nxt = cz_r + CW'(1);
        end else if (y_hit) begin
          lab_wd   = aae_pkg::LAB_Y;
          cy_nxt   = cy_r + CW'(1);
          free_nxt = free_r - $signed(LW'(1));
        end else begin
          lab_wd   = aae_pkg::LAB_X;
          free_nxt = free_r - $signed(LW'(1));
        end
        if (i_r == '0) begin
          go_tally = 1'b1;
        end else begin
          i_nxt = i_r - CW'(1);
        end
      end

      S_TALLY: begin
        if (i_r == d_w) begin
          state_nxt = S_OUT;
        end else begin
          case (lab_r[i_r[IW-1:0]])
            aae_pkg::LAB_X: tx_nxt = tx_r + CW'(1);
            aae_pkg::LAB_Y: ty_nxt = ty_r + CW'(1);
            aae_pkg::LAB_Z: tz_nxt = tz_r + CW'(1);
            default: begin
            end
          endcase
          i_nxt = i_r + CW'(1);
        end
      end

      S_OUT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go_tally) begin
      state_nxt = S_TALLY;
      i_nxt     = '0;
      tx_nxt    = '0;
      ty_nxt    = '0;
      tz_nxt    = '0;
    end
    if (go_zrst) begin
      state_nxt = S_ZRST;
      i_nxt     = '0;
    end
    if (go_build) begin
      state_nxt = S_BUILD;
      i_nxt     = d_w - CW'(1);
      cz_nxt    = '0;
      cy_nxt    = '0;
      free_nxt  = span_y_w - $signed(LW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      cnt_x_r <= '0;
      cnt_y_r <= '0;
      cnt_z_r <= '0;
      fin_r   <= 1'b0;
      bad_r   <= 1'b0;
      sel_r   <= 1'b0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      cnt_x_r <= cnt_x_nxt;
      cnt_y_r <= cnt_y_nxt;
      cnt_z_r <= cnt_z_nxt;
      fin_r   <= fin_nxt;
      bad_r   <= bad_nxt;
      sel_r   <= sel_nxt;
      i_r     <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nz_r   <= nz_nxt;
    ny_r   <= ny_nxt;
    lim_r  <= lim_nxt;
    v_r    <= v_nxt;
    cz_r   <= cz_nxt;
    cy_r   <= cy_nxt;
    free_r <= free_nxt;
    tx_r   <= tx_nxt;
    ty_r   <= ty_nxt;
    tz_r   <= tz_nxt;
    if (z_we) begin
      z_pos_r[z_wa] <= z_wd;
    end
    if (y_we) begin
      y_pos_r[y_wa] <= y_wd;
    end
    if (lab_we) begin
      lab_r[lab_wa] <= lab_wd;
    end
  end

  // packed labels for positions below the degree
  for (genvar g = 0; g < aae_pkg::AXES_POS; g++) begin : g_axes
    if (g < MAX_DEGREE) begin : g_live
      assign axes_w[2*g +: 2] = (CW'(g) < d_w) ? lab_r[g] : 2'b00;
    end else begin : g_dead
      assign axes_w[2*g +: 2] = 2'b00;
    end
  end

  assign out_load = (state_r == S_OUT) && slot_free;

  always_comb begin
    req_w.axes  = axes_w;
    req_w.done  = fin_r;
    req_w.bad   = bad_r;
    req_w.tal_x = aae_pkg::TAL_W'(tx_r);
    req_w.tal_y = aae_pkg::TAL_W'(ty_r);
    req_w.tal_z = aae_pkg::TAL_W'(tz_r);
    req_w.cnt_x = cnt_x_r;
    req_w.cnt_y = cnt_y_r;
    req_w.cnt_z = cnt_z_r;
  end

  aae_out_stage u_out (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .load                  (out_load),
    .req                   (req_w),
    .slot_free             (slot_free),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_axes              (out_axes),
    .out_done_res          (out_done_res),
    .out_bad_args          (out_bad_args),
    .out_arrangement_valid (out_arrangement_valid),
    .out_function_index    (out_function_index)
  );

endmodule

/* rtl/aae_checker.sv */
`timescale 1ns / 1ps

module aae_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [aae_pkg::AXES_W-1:0]  out_axes,
  input logic                        out_done_res,
  input logic                        out_bad_args
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_axes) && $stable(out_done_res))
    else $error("stalled result changed");

  // one item at a time: after an accept the input side is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

  // a rejected start also ends the enumeration
  a_bad_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_args |-> out_done_res)
    else $error("bad start without done");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind axis_arrangement_enumerator aae_checker u_aae_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_axes     (out_axes),
  .out_done_res (out_done_res),
  .out_bad_args (out_bad_args)
);
